/* src/cba3d_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cba3d_pkg
// Shared types and constants of the clipped 3D box average block.
// ---------------------------------------------------------------------------
package cba3d_pkg;

  localparam int unsigned MaxExtentDef  = 256;
  localparam int unsigned StoreDepthDef = 65536;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned MaxPatchDef   = 32;

  localparam int unsigned DimBits   = 9;
  localparam int unsigned PatchBits = 6;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned InSampleBits = 16;
  localparam int unsigned MeanBits  = 25;
  localparam int unsigned CountBits = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 9;

  localparam logic [CfgIdxBits-1:0] RegDimX    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegDimY    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegDimZ    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegPatchX  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegPatchY  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegPatchZ  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegSigned  = 3'd6;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [CoordBits-1:0]    coord_x;
    logic [CoordBits-1:0]    coord_y;
    logic [CoordBits-1:0]    coord_z;
    logic [InSampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [MeanBits-1:0] mean;
    logic                       empty_res;
    logic [CountBits-1:0]       voxel_count;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // register the accepted item
    logic do_load;   // write the store
    logic init_win;  // set window counters to their start
    logic step;      // issue one window read and advance
    logic accum;     // add the sample read last cycle
    logic div_start; // start the divider
    logic div_step;  // one restoring step
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_query;
    logic win_last;  // current step is the final window position
    logic win_empty; // window has no positions at all
    logic div_done;
  } stat_t;

endpackage

/* src/clipped_box_average_3d.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_box_average_3d
// Windowed mean over a stored voxel volume, clipped at the volume edges.
// ---------------------------------------------------------------------------
// A load writes its voxel to the store when it lies in the volume. A query
// walks a window of size W on each axis, where W is the patch size rounded
// down to even; a window of size zero on some axis skips the walk. The walk
// reads one voxel per cycle from the single-port volume store, then a
// restoring divider of NumBits bits (41 at the defaults) yields one quotient
// bit per cycle. Items are taken one at a time; the result stays on the
// output until taken, and the next item is taken after that.
module clipped_box_average_3d #(
  parameter int unsigned MAX_EXTENT  = cba3d_pkg::MaxExtentDef,
  parameter int unsigned STORE_DEPTH = cba3d_pkg::StoreDepthDef,
  parameter int unsigned SAMPLE_BITS = cba3d_pkg::SampleBitsDef,
  parameter int unsigned MAX_PATCH   = cba3d_pkg::MaxPatchDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cba3d_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cba3d_pkg::out_item_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cba3d_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [cba3d_pkg::CfgDataBits-1:0] cfg_data_i
);
  import cba3d_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  cba3d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  cba3d_datapath #(
    .MAX_EXTENT(MAX_EXTENT), .STORE_DEPTH(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS), .MAX_PATCH(MAX_PATCH)
  ) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cmd_i(cmd), .stat_o(stat), .result_o(out_data_o)
  );

endmodule

/* src/cba3d_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cba3d_datapath
// Volume store, window walker, accumulator and serial divider.
// ---------------------------------------------------------------------------
module cba3d_datapath #(
  parameter int unsigned MAX_EXTENT  = cba3d_pkg::MaxExtentDef,
  parameter int unsigned STORE_DEPTH = cba3d_pkg::StoreDepthDef,
  parameter int unsigned SAMPLE_BITS = cba3d_pkg::SampleBitsDef,
  parameter int unsigned MAX_PATCH   = cba3d_pkg::MaxPatchDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cba3d_pkg::in_item_t               item_i,
  input  logic                              cfg_valid_i,
  input  logic [cba3d_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [cba3d_pkg::CfgDataBits-1:0] cfg_data_i,
  input  cba3d_pkg::cmd_t                   cmd_i,
  output cba3d_pkg::stat_t                  stat_o,
  output cba3d_pkg::out_item_t              result_o
);
  import cba3d_pkg::*;

  localparam int unsigned AddrBits = $clog2(STORE_DEPTH);
  localparam int unsigned ExtBits  = $clog2(MAX_EXTENT + 1);
  localparam int unsigned HBits    = $clog2(MAX_PATCH / 2 + 1);
  // Signed position: coordinate minus half patch, plus room for sign.
  localparam int unsigned PosBits  = ((ExtBits > CoordBits) ? ExtBits : CoordBits) + 2;
  // Address product width: enough for z*dx*dy with z below MAX_EXTENT.
  localparam int unsigned ProdBits = 3 * ExtBits;
  localparam int unsigned NumBits  = SAMPLE_BITS + 3 * HBits + 2 + 8;
  localparam int unsigned CntBits  = 3 * HBits + 3;
  localparam int unsigned MaxExtC  = MAX_EXTENT;
  localparam int unsigned MaxHC    = MAX_PATCH / 2;
  localparam int unsigned DepthC   = STORE_DEPTH;
  localparam int unsigned QBits    = NumBits;
  localparam int unsigned DivSteps = NumBits;
  localparam int unsigned DsBits   = $clog2(DivSteps + 1);

  // Configuration registers.
  logic [DimBits-1:0]   dim_x_q, dim_y_q, dim_z_q;
  logic [PatchBits-1:0] patch_x_q, patch_y_q, patch_z_q;
  logic                 signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DimBits'(1);
      dim_y_q <= DimBits'(1);
      dim_z_q <= DimBits'(1);
      patch_x_q <= PatchBits'(2);
      patch_y_q <= PatchBits'(2);
      patch_z_q <= PatchBits'(2);
      signed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDimX:   dim_x_q <= cfg_data_i;
        RegDimY:   dim_y_q <= cfg_data_i;
        RegDimZ:   dim_z_q <= cfg_data_i;
        RegPatchX: patch_x_q <= cfg_data_i[PatchBits-1:0];
        RegPatchY: patch_y_q <= cfg_data_i[PatchBits-1:0];
        RegPatchZ: patch_z_q <= cfg_data_i[PatchBits-1:0];
        RegSigned: signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [ExtBits-1:0] sat_ext(input logic [DimBits-1:0] d);
    logic [31:0] w;
    w = 32'(d);
    return (w > MaxExtC) ? ExtBits'(MaxExtC) : ExtBits'(w);
  endfunction

  function automatic logic [HBits-1:0] half(input logic [PatchBits-1:0] p);
    logic [31:0] w;
    w = 32'(p) >> 1;
    return (w > MaxHC) ? HBits'(MaxHC) : HBits'(w);
  endfunction

  logic [ExtBits-1:0] dx, dy, dz;
  logic [HBits-1:0]   hx, hy, hz;
  assign dx = sat_ext(dim_x_q);
  assign dy = sat_ext(dim_y_q);
  assign dz = sat_ext(dim_z_q);
  assign hx = half(patch_x_q);
  assign hy = half(patch_y_q);
  assign hz = half(patch_z_q);

  // Plane size registered so the address path has one multiplier a stage.
  logic [2*ExtBits-1:0] plane_q;
  always_ff @(posedge clk_i) plane_q <= (2*ExtBits)'(dx) * (2*ExtBits)'(dy);

  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  // Window walker, signed positions.
  logic signed [PosBits-1:0] px_q, py_q, pz_q;
  logic signed [PosBits-1:0] sx, sy, sz, ex, ey, ez;
  assign sx = $signed(PosBits'(item_q.coord_x)) - $signed(PosBits'(hx));
  assign sy = $signed(PosBits'(item_q.coord_y)) - $signed(PosBits'(hy));
  assign sz = $signed(PosBits'(item_q.coord_z)) - $signed(PosBits'(hz));
  assign ex = $signed(PosBits'(item_q.coord_x)) + $signed(PosBits'(hx)) - PosBits'(1);
  assign ey = $signed(PosBits'(item_q.coord_y)) + $signed(PosBits'(hy)) - PosBits'(1);
  assign ez = $signed(PosBits'(item_q.coord_z)) + $signed(PosBits'(hz)) - PosBits'(1);

  logic lx, ly, lz;
  assign lx = (px_q == ex);
  assign ly = (py_q == ey);
  assign lz = (pz_q == ez);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_win) begin
      px_q <= sx; py_q <= sy; pz_q <= sz;
    end else if (cmd_i.step) begin
      if (!lx) px_q <= px_q + PosBits'(1);
      else begin
        px_q <= sx;
        if (!ly) py_q <= py_q + PosBits'(1);
        else begin
          py_q <= sy;
          pz_q <= pz_q + PosBits'(1);
        end
      end
    end
  end

  // Inside test for the current position.
  logic inx, iny, inz, inside_w;
  assign inx = (px_q >= 0) && (px_q < $signed(PosBits'(dx)));
  assign iny = (py_q >= 0) && (py_q < $signed(PosBits'(dy)));
  assign inz = (pz_q >= 0) && (pz_q < $signed(PosBits'(dz)));
  assign inside_w = inx && iny && inz;

  // Address for either a load (captured item) or a window read.
  logic [ExtBits-1:0] ax, ay, az;
  logic use_win;
  assign use_win = cmd_i.step;
  assign ax = use_win ? px_q[ExtBits-1:0] : ExtBits'(item_q.coord_x);
  assign ay = use_win ? py_q[ExtBits-1:0] : ExtBits'(item_q.coord_y);
  assign az = use_win ? pz_q[ExtBits-1:0] : ExtBits'(item_q.coord_z);

  logic [ProdBits-1:0] row_w, zpl_w, addr_full;
  assign row_w = ProdBits'(ay) * ProdBits'(dx);
  assign zpl_w = ProdBits'(az) * ProdBits'(plane_q);
  assign addr_full = zpl_w + row_w + ProdBits'(ax);

  logic in_store;
  assign in_store = (ProdBits + 1)'(addr_full) < (ProdBits + 1)'(DepthC);

  logic load_in;
  assign load_in = (ExtBits'(item_q.coord_x) < dx) && (ExtBits'(item_q.coord_y) < dy)
                && (ExtBits'(item_q.coord_z) < dz);

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   rd_valid_q, rd_zero_q;
  logic [AddrBits-1:0]    addr;
  logic [SAMPLE_BITS-1:0] wr_sample;
  assign addr = addr_full[AddrBits-1:0];
  assign wr_sample = SAMPLE_BITS'(item_q.sample);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load && load_in && in_store) mem[addr] <= wr_sample;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.step && inside_w;
      rd_zero_q  <= !in_store;
    end
  end

  // Accumulator.
  logic signed [NumBits-1:0] sum_q;
  logic [CntBits-1:0]        cnt_q;
  logic signed [NumBits-1:0] smp;
  assign smp = rd_zero_q ? '0 :
               (signed_q ? NumBits'($signed(rd_q)) : $signed(NumBits'(rd_q)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_win) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accum && rd_valid_q) begin
      sum_q <= sum_q + smp;
      cnt_q <= cnt_q + CntBits'(1);
    end
  end

  // Restoring divider on magnitudes, one quotient bit a cycle.
  logic [QBits-1:0]   rem_q, quo_q;
  logic [NumBits-1:0] num_mag;
  logic               neg_q;
  logic [DsBits-1:0]  ds_q;
  logic [QBits:0]     trial;
  logic [QBits-1:0]   rem_sh;
  logic [NumBits-1:0] sum_sh;
  assign sum_sh = NumBits'(sum_q <<< 8);
  assign num_mag = sum_q[NumBits-1] ? NumBits'(-sum_sh) : sum_sh;
  assign rem_sh = {rem_q[QBits-2:0], quo_q[QBits-1]};
  assign trial = {1'b0, rem_sh} - (QBits + 1)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= num_mag;
      neg_q <= sum_q[NumBits-1];
      ds_q  <= DsBits'(DivSteps);
    end else if (cmd_i.div_step) begin
      ds_q <= ds_q - DsBits'(1);
      if (!trial[QBits]) begin
        rem_q <= trial[QBits-1:0];
        quo_q <= {quo_q[QBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QBits-2:0], 1'b0};
      end
    end
  end

  logic [QBits-1:0] qs;
  assign qs = neg_q ? QBits'(-quo_q) : quo_q;

  assign stat_o.is_query  = (item_q.operation == OpQuery);
  assign stat_o.win_last  = lx && ly && lz;
  assign stat_o.win_empty = (hx == '0) || (hy == '0) || (hz == '0);
  assign stat_o.div_done  = (ds_q == '0);

  assign result_o.mean        = (cnt_q == '0) ? '0 : MeanBits'(qs);
  assign result_o.empty_res   = (cnt_q == '0);
  assign result_o.voxel_count = CountBits'(cnt_q);

endmodule

/* src/cba3d_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cba3d_ctrl
// Sequencer for load, window walk, divide and result handoff.
// ---------------------------------------------------------------------------
module cba3d_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  cba3d_pkg::stat_t stat_i,
  output cba3d_pkg::cmd_t  cmd_o
);
  import cba3d_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StWalk, StDrain, StDivInit, StDiv, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.capture   = (state_q == StIdle) && in_valid_i;
    cmd_o.do_load   = (state_q == StDecode) && !stat_i.is_query;
    cmd_o.init_win  = (state_q == StDecode);
    cmd_o.step      = (state_q == StWalk);
    cmd_o.accum     = (state_q == StWalk) || (state_q == StDrain);
    cmd_o.div_start = (state_q == StDivInit);
    cmd_o.div_step  = (state_q == StDiv) && !stat_i.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle:   if (in_valid_i) state_q <= StDecode;
        StDecode: begin
          if (!stat_i.is_query) state_q <= StIdle;
          else if (stat_i.win_empty) state_q <= StDivInit;
          else state_q <= StWalk;
        end
        StWalk:   if (stat_i.win_last) state_q <= StDrain;
        StDrain:  state_q <= StDivInit;
        StDivInit: state_q <= StDiv;
        StDiv: begin
          if (stat_i.div_done) begin
            state_q <= StOut;
            out_valid_q <= 1'b1;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            state_q <= StIdle;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == StOut) else $error("result shown outside output state");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !out_valid_q) else $error("capture while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("stalled result dropped");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for clipped_box_average_3d. Load and query transactions
// are generated per register setting. Each query's window is covered with
// loads beforehand, so that no entry is read before it has been written.
// A scoreboard predicts each window mean and checks the results in order.
// ---------------------------------------------------------------------------
module testbench;
  import cba3d_pkg::*;

  localparam int unsigned Depth = StoreDepthDef;
  localparam int unsigned WatchLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  clipped_box_average_3d dut (.*);

  always #5 clk_i = ~clk_i;

  // Register copies used by both the generator and the mean predictor.
  logic [DimBits-1:0] dim_reg[3];
  logic [PatchBits-1:0] patch_reg[3];
  logic signed_reg;

  logic [15:0] voxel_mem[Depth];     // predicted store contents
  bit loaded_map[Depth];             // entries the stimulus has written
  in_item_t pending_items[$];
  out_item_t expected_means[$];
  int idle_mode = 0;
  logic in_taken = 1'b0;
  bit failed = 1'b0;
  int quiet_cycles = 0;

  function automatic longint eff_dim(int a);
    return (dim_reg[a] > MaxExtentDef) ? MaxExtentDef : dim_reg[a];
  endfunction

  function automatic longint half_win(int a);
    return ((patch_reg[a] > MaxPatchDef) ? MaxPatchDef : patch_reg[a]) / 2;
  endfunction

  function automatic out_item_t predict_mean(in_item_t it);
    longint dx, dy, dz, sum, cnt, mean, addr, x, y, z;
    logic [15:0] v;
    out_item_t res;
    dx = eff_dim(0);
    dy = eff_dim(1);
    dz = eff_dim(2);
    sum = 0;
    cnt = 0;
    mean = 0;
    for (longint k = -half_win(2); k < half_win(2); k++) begin
      z = it.coord_z + k;
      if (z < 0 || z >= dz) continue;
      for (longint j = -half_win(1); j < half_win(1); j++) begin
        y = it.coord_y + j;
        if (y < 0 || y >= dy) continue;
        for (longint i = -half_win(0); i < half_win(0); i++) begin
          x = it.coord_x + i;
          if (x < 0 || x >= dx) continue;
          addr = z * dx * dy + y * dx + x;
          if (addr < Depth) begin
            v = voxel_mem[addr];
            sum += (signed_reg && v[15]) ? longint'(v) - 65536 : longint'(v);
          end
          cnt++;
        end
      end
    end
    if (cnt > 0) mean = (sum * 256) / cnt;
    res.mean = mean[MeanBits-1:0];
    res.empty_res = (cnt == 0);
    res.voxel_count = cnt[CountBits-1:0];
    return res;
  endfunction

  // Raster address of an in-extent voxel, or -1 when the load is dropped.
  function automatic longint load_addr(in_item_t it);
    longint addr;
    if (it.coord_x >= eff_dim(0) || it.coord_y >= eff_dim(1) || it.coord_z >= eff_dim(2))
      return -1;
    addr = it.coord_z * eff_dim(0) * eff_dim(1) + it.coord_y * eff_dim(0) + it.coord_x;
    return (addr < Depth) ? addr : -1;
  endfunction

  function automatic void push_load(int x, int y, int z, logic [15:0] s);
    in_item_t it;
    longint addr;
    it.operation = OpLoad;
    it.coord_x = CoordBits'(x);
    it.coord_y = CoordBits'(y);
    it.coord_z = CoordBits'(z);
    it.sample = s;
    addr = load_addr(it);
    if (addr >= 0) loaded_map[addr] = 1'b1;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Any voxel of the window that has never been written gets a load first.
  function automatic void push_query(int x, int y, int z);
    longint addr;
    in_item_t it;
    for (longint k = z - half_win(2); k < z + half_win(2); k++)
      for (longint j = y - half_win(1); j < y + half_win(1); j++)
        for (longint i = x - half_win(0); i < x + half_win(0); i++) begin
          if (i < 0 || j < 0 || k < 0) continue;
          if (i >= eff_dim(0) || j >= eff_dim(1) || k >= eff_dim(2)) continue;
          addr = k * eff_dim(0) * eff_dim(1) + j * eff_dim(0) + i;
          if (addr < Depth && !loaded_map[addr])
            push_load(int'(i), int'(j), int'(k), rand_sample());
        end
    it.operation = OpQuery;
    it.coord_x = CoordBits'(x);
    it.coord_y = CoordBits'(y);
    it.coord_z = CoordBits'(z);
    it.sample = InSampleBits'($urandom_range(16'hFFFF));
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic int rand_coord(int a);
    if ($urandom_range(9) == 0) return int'($urandom_range(255));
    return int'($urandom_range((eff_dim(a) + 1 > 255) ? 255 : eff_dim(a) + 1));
  endfunction

  function automatic void gen_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 40)
        push_query(rand_coord(0), rand_coord(1), rand_coord(2));
      else
        push_load(rand_coord(0), rand_coord(1), rand_coord(2), rand_sample());
    end
  endfunction

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDimX: dim_reg[0] = val;
      RegDimY: dim_reg[1] = val;
      RegDimZ: dim_reg[2] = val;
      RegPatchX: patch_reg[0] = val[PatchBits-1:0];
      RegPatchY: patch_reg[1] = val[PatchBits-1:0];
      RegPatchZ: patch_reg[2] = val[PatchBits-1:0];
      RegSigned: signed_reg = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(int dx, int dy, int dz, int px, int py, int pz, bit sg);
    cfg_write(RegDimX, CfgDataBits'(dx));
    cfg_write(RegDimY, CfgDataBits'(dy));
    cfg_write(RegDimZ, CfgDataBits'(dz));
    cfg_write(RegPatchX, CfgDataBits'(px));
    cfg_write(RegPatchY, CfgDataBits'(py));
    cfg_write(RegPatchZ, CfgDataBits'(pz));
    cfg_write(RegSigned, CfgDataBits'(sg));
  endtask

  // Waits until every queued transaction is done and every mean is in.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_means.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_phase(int n);
    push_query(0, 0, 0);
    push_query(255, 255, 255);
    push_query(int'(eff_dim(0) - 1 < 0 ? 0 : eff_dim(0) - 1),
               int'(eff_dim(1) - 1 < 0 ? 0 : eff_dim(1) - 1),
               int'(eff_dim(2) - 1 < 0 ? 0 : eff_dim(2) - 1));
    gen_random(n / 2);
    drain();
    gen_random(n - n / 2);
    drain();
  endtask

  // Driver: a new transaction is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_items.size() != 0 &&
            $urandom_range(99) >= (idle_mode == 0 ? 8 : idle_mode == 1 ? 54 : 0)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= $urandom_range(99) < (idle_mode == 0 ? 54 : idle_mode == 1 ? 8 : 0);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk_i) begin
    out_item_t exp_res;
    bit moved;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      moved = (cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
              (out_valid_o && !out_stall_i);
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.operation == OpQuery) begin
          expected_means.insert(expected_means.size(), predict_mean(in_data_i));
        end else if (load_addr(in_data_i) >= 0) begin
          voxel_mem[load_addr(in_data_i)] = in_data_i.sample;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_means.size() == 0) begin
          $error("unexpected result transaction");
          failed = 1'b1;
        end else begin
          exp_res = expected_means.pop_front();
          if (out_data_o.mean !== exp_res.mean) begin
            $error("mean: expected %0d, got %0d", exp_res.mean, out_data_o.mean);
            failed = 1'b1;
          end
          if (out_data_o.empty_res !== exp_res.empty_res) begin
            $error("empty_res: expected %0d, got %0d", exp_res.empty_res,
                   out_data_o.empty_res);
            failed = 1'b1;
          end
          if (out_data_o.voxel_count !== exp_res.voxel_count) begin
            $error("voxel_count: expected %0d, got %0d", exp_res.voxel_count,
                   out_data_o.voxel_count);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("[clipped_box_average_3d] ERROR");
        $finish;
      end
    end
  end

  initial begin
    dim_reg = '{1, 1, 1};
    patch_reg = '{2, 2, 2};
    signed_reg = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: a one-voxel volume.
    push_load(0, 0, 0, 16'hFFFF);
    push_query(0, 0, 0);
    push_load(255, 255, 255, 16'h1234);
    push_query(255, 255, 255);
    push_query(1, 1, 1);
    drain();

    // Largest window over a small volume, clipped on every side.
    configure(4, 4, 4, 32, 32, 32, 1'b0);
    run_phase(10);
    // Long thin volume; a patch of size one gives an empty window.
    configure(256, 1, 1, 32, 1, 3, 1'b1);
    run_phase(12);
    configure(256, 1, 1, 3, 2, 2, 1'b1);
    run_phase(12);
    idle_mode = 1;
    // Oversized extents saturate; most of the volume lies beyond the store.
    configure(511, 256, 256, 4, 4, 4, 1'b1);
    push_query(3, 3, 1);
    run_phase(10);
    // Zero extent: nothing is loaded, every window is empty.
    configure(0, 5, 5, 2, 2, 2, 1'b0);
    run_phase(10);
    // Oversized patch saturates.
    configure(16, 2, 2, 63, 5, 3, 1'b1);
    run_phase(10);
    for (int p = 0; p < 6; p++) begin
      idle_mode = (p < 3) ? 1 : 2;
      configure($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(4, 1),
                $urandom_range(6), $urandom_range(6), $urandom_range(6),
                $urandom_range(1));
      run_phase(25);
    end

    if (!failed) begin
      $display("[clipped_box_average_3d] OK");
    end else begin
      $display("[clipped_box_average_3d] ERROR");
    end
    $finish;
  end

endmodule
